// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked property, skipped while reset is high
`define ASSERT_CLK_RST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// checked property, also during reset
`define ASSERT_CLK(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_CLK(lbl, clk_s, prop, msg)
`endif

`endif

// ===== design/dvtu_pkg.sv =====
// ----------------------------------------------------------------------------
// dvtu_pkg
// types and codes of the distance vector table update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dvtu_pkg;

  localparam int IdxW  = 5;
  localparam int CostW = 16;
  localparam int AddrW = 32;

  localparam logic [1:0] ACT_UNCHANGED = 2'd0;
  localparam logic [1:0] ACT_UPDATED   = 2'd1;
  localparam logic [1:0] ACT_INSERTED  = 2'd2;
  localparam logic [1:0] ACT_FULL      = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] adv_dest;
    logic [CostW-1:0] adv_cost;
    logic [AddrW-1:0] sender;
    logic [AddrW-1:0] arrival_interface;
    logic [CostW-1:0] link_cost;
  } adv_item_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [IdxW-1:0]  entry_index;
    logic [CostW-1:0] result_cost;
    logic [AddrW-1:0] result_next_hop;
  } route_result_t;

  typedef struct packed {
    logic [AddrW-1:0] dest;
    logic [AddrW-1:0] next_hop;
    logic [AddrW-1:0] iface;
    logic [CostW-1:0] cost;
  } route_t;

endpackage

// ===== design/dvtu_route_mem.sv =====
// ----------------------------------------------------------------------------
// dvtu_route_mem
// route table storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dvtu_route_mem
  import dvtu_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  route_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output route_t        rdata
);

  route_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/distance_vector_table_update.sv =====
// ----------------------------------------------------------------------------
// distance_vector_table_update
// distance vector route table: relax one advertised entry per command
// ----------------------------------------------------------------------------
//
// channel   signals                 transfer
// --------  ----------------------  ------------------------------------
// command   start, busy, item       start high and busy low at clk edge
// result    done, result            done high for one cycle, no stall
// config    cfg_we, cfg_wdata       cfg_we high at clk edge
//
// from its transfer to the done strobe an item passes the saturated sum, a
// scan of the stored entries (skipped while the table is empty) and a
// final step that decides and writes back
// rst (synchronous) empties the table and sets the infinity limit to 999
// busy falls in the cycle that shows done, so a new command can transfer
// while the result is on the ports; the receiver cannot stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module distance_vector_table_update
  import dvtu_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  adv_item_t         item,
  output logic              done,
  output route_result_t     result,
  input  logic              cfg_we,
  input  logic [CostW-1:0]  cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_MATCH,
    ST_APPEND
  } state_t;

  state_t           state;
  adv_item_t        req;
  logic [CostW-1:0] cand;
  logic [AW-1:0]    scan_idx;
  logic [CW-1:0]    count;
  logic [CostW-1:0] inf_limit;

  // memory controls
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  route_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  route_t        mem_rdata;

  logic [CostW:0] sum;
  logic [CW-1:0]  scan_next;
  logic           hit;
  logic           last;
  logic           fire;
  logic           changed;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      inf_limit <= CostW'(999);
    end else if (cfg_we) begin
      inf_limit <= cfg_wdata;
    end
  end

  // candidate cost, saturated at infinity
  assign sum = {1'b0, req.adv_cost} + {1'b0, req.link_cost};

  // scan compare against the entry read last cycle
  assign scan_next = CW'(scan_idx) + CW'(1);
  assign hit       = (mem_rdata.dest == req.adv_dest);
  assign last      = (scan_next == count);

  // relaxation rule for a matched route
  assign fire    = (mem_rdata.next_hop == req.sender) || (mem_rdata.cost > cand);
  assign changed = fire && ((mem_rdata.cost != cand) || (mem_rdata.next_hop != req.sender));

  assign busy = (state != ST_IDLE);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = scan_idx;
    mem_wdata = mem_rdata;
    case (state)
      ST_CALC: begin
        mem_re    = (count != '0);
        mem_raddr = '0;
      end
      ST_SCAN: begin
        // fetch the next entry unless this one ends the scan
        mem_re    = !hit && !last;
        mem_raddr = AW'(scan_next);
      end
      ST_MATCH: begin
        // rewrite cost and next hop, keep dest and interface
        mem_we             = changed;
        mem_waddr          = scan_idx;
        mem_wdata          = mem_rdata;
        mem_wdata.cost     = cand;
        mem_wdata.next_hop = req.sender;
      end
      ST_APPEND: begin
        mem_we             = (count != FullCount);
        mem_waddr          = AW'(count);
        mem_wdata.dest     = req.adv_dest;
        mem_wdata.next_hop = req.sender;
        mem_wdata.iface    = req.arrival_interface;
        mem_wdata.cost     = cand;
      end
      default: begin
      end
    endcase
  end

  // sequencer, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            req   <= item;
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          done     <= 1'b0;
          cand     <= (sum > {1'b0, inf_limit}) ? inf_limit : sum[CostW-1:0];
          scan_idx <= '0;
          state    <= (count == '0) ? ST_APPEND : ST_SCAN;
        end
        ST_SCAN: begin
          done <= 1'b0;
          if (hit) begin
            state <= ST_MATCH;
          end else if (last) begin
            state <= ST_APPEND;
          end else begin
            scan_idx <= AW'(scan_next);
          end
        end
        ST_MATCH: begin
          done               <= 1'b1;
          result.entry_index <= IdxW'(scan_idx);
          if (changed) begin
            result.action          <= ACT_UPDATED;
            result.result_cost     <= cand;
            result.result_next_hop <= req.sender;
          end else begin
            result.action          <= ACT_UNCHANGED;
            result.result_cost     <= mem_rdata.cost;
            result.result_next_hop <= mem_rdata.next_hop;
          end
          state <= ST_IDLE;
        end
        ST_APPEND: begin
          done <= 1'b1;
          if (count == FullCount) begin
            // table full, nothing stored
            result.action          <= ACT_FULL;
            result.entry_index     <= '0;
            result.result_cost     <= '0;
            result.result_next_hop <= '0;
          end else begin
            result.action          <= ACT_INSERTED;
            result.entry_index     <= IdxW'(count);
            result.result_cost     <= cand;
            result.result_next_hop <= req.sender;
            count                  <= count + CW'(1);
          end
          state <= ST_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  dvtu_route_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // checks
  `ASSERT_CLK_RST(a_done_after_work, clk, rst, done |-> $past(busy), "result without work")
  `ASSERT_CLK_RST(a_cmd_takes_busy, clk, rst, (start && !busy) |=> busy, "command not taken")
  `ASSERT_CLK_RST(a_count_bound, clk, rst, count <= FullCount, "entry count above depth")
  `ASSERT_CLK_RST(a_insert_counts, clk, rst, (done && result.action == ACT_INSERTED) |-> (count == $past(count) + CW'(1)), "insert without count step")
  `ASSERT_CLK_RST(a_full_only_full, clk, rst, (done && result.action == ACT_FULL) |-> (count == FullCount), "drop with free slot")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the distance vector route table update
// ----------------------------------------------------------------------------
// a directed table walks insertion, forced rewrites, cheaper routes, cost
// saturation and the zero and lowered infinity cases, then random
// advertisements run in phases under several infinity settings, most of them
// aimed at known destinations. every result transfer is checked field by field
// against a typed plan result or a route table model kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dvtu_pkg::*;

  localparam int RouteDepth  = 32;
  localparam int WatchLimit  = 4000;
  localparam int PhaseItems  = 240;
  localparam int PhaseCount  = 6;
  localparam int MaxReported = 10;

  // one line of the directed plan: a register write or an advertisement
  typedef struct {
    bit               is_cfg;
    logic [CostW-1:0] cfg_val;
    adv_item_t        adv;
    bit               typed;
    route_result_t    want;
  } plan_row_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          start     = 1'b0;
  adv_item_t     item      = '0;
  logic          cfg_we    = 1'b0;
  logic [CostW-1:0] cfg_wdata = '0;
  logic          busy;
  logic          done;
  route_result_t result;

  distance_vector_table_update #(
    .TABLE_DEPTH(RouteDepth)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bench copy of the route table and the infinity register
  logic [AddrW-1:0] route_dest_m [RouteDepth];
  logic [AddrW-1:0] route_hop_m  [RouteDepth];
  logic [AddrW-1:0] route_ifc_m  [RouteDepth];
  logic [CostW-1:0] route_cost_m [RouteDepth];
  int               routes_used = 0;
  logic [CostW-1:0] infinity_m  = 16'd999;

  route_result_t pending_routes[$];
  int            mismatches  = 0;
  int            burst_left  = 0;
  int            quiet_count = 0;
  plan_row_t     plan[$];

  // append one row to the directed plan
  function automatic void add_row(plan_row_t p);
    plan.insert(plan.size(), p);
  endfunction

  // one relaxation step on the bench table, returns the expected result
  function automatic route_result_t relax_route(adv_item_t a);
    logic [CostW:0]   sum;
    logic [CostW-1:0] cand;
    route_result_t    r;
    bit               fire;
    sum  = {1'b0, a.adv_cost} + {1'b0, a.link_cost};
    cand = (sum > {1'b0, infinity_m}) ? infinity_m : sum[CostW-1:0];
    for (int i = 0; i < routes_used; i++) begin
      if (route_dest_m[i] == a.adv_dest) begin
        // rewrite on same next hop or strictly cheaper; stored cost not re-capped
        fire = (route_hop_m[i] == a.sender) || (route_cost_m[i] > cand);
        r.action = ACT_UNCHANGED;
        if (fire && (route_cost_m[i] != cand || route_hop_m[i] != a.sender)) begin
          route_cost_m[i] = cand;
          route_hop_m[i]  = a.sender;
          r.action        = ACT_UPDATED;
        end
        r.entry_index     = IdxW'(i);
        r.result_cost     = route_cost_m[i];
        r.result_next_hop = route_hop_m[i];
        return r;
      end
    end
    if (routes_used >= RouteDepth) begin
      // table full: everything but the action reads zero
      r        = '0;
      r.action = ACT_FULL;
      return r;
    end
    route_dest_m[routes_used] = a.adv_dest;
    route_hop_m[routes_used]  = a.sender;
    route_ifc_m[routes_used]  = a.arrival_interface;
    route_cost_m[routes_used] = cand;
    r.action          = ACT_INSERTED;
    r.entry_index     = IdxW'(routes_used);
    r.result_cost     = cand;
    r.result_next_hop = a.sender;
    routes_used++;
    return r;
  endfunction

  function automatic adv_item_t mk_adv(logic [AddrW-1:0] dest, logic [CostW-1:0] acost,
                                       logic [AddrW-1:0] from, logic [AddrW-1:0] ifc,
                                       logic [CostW-1:0] lcost);
    adv_item_t a;
    a.adv_dest          = dest;
    a.adv_cost          = acost;
    a.sender            = from;
    a.arrival_interface = ifc;
    a.link_cost         = lcost;
    return a;
  endfunction

  function automatic route_result_t mk_res(logic [1:0] act, int idx, logic [CostW-1:0] cost,
                                           logic [AddrW-1:0] hop);
    route_result_t r;
    r.action          = act;
    r.entry_index     = IdxW'(idx);
    r.result_cost     = cost;
    r.result_next_hop = hop;
    return r;
  endfunction

  function automatic plan_row_t adv_row(adv_item_t a, bit typed, route_result_t want);
    plan_row_t p;
    p.is_cfg  = 1'b0;
    p.cfg_val = '0;
    p.adv     = a;
    p.typed   = typed;
    p.want    = want;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic [CostW-1:0] v);
    plan_row_t p;
    p.is_cfg  = 1'b1;
    p.cfg_val = v;
    p.adv     = '0;
    p.typed   = 1'b0;
    p.want    = '0;
    return p;
  endfunction

  // costs lean small so that relaxation decisions are close calls
  function automatic logic [CostW-1:0] random_cost();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return CostW'($urandom);
      4:       return infinity_m >> 1;
      default: return CostW'($urandom_range(0, 40));
    endcase
  endfunction

  // mostly known destinations with the current or a familiar next hop
  function automatic adv_item_t random_adv();
    adv_item_t a;
    int        slot;
    a.arrival_interface = $urandom;
    a.adv_cost          = random_cost();
    a.link_cost         = random_cost();
    if (routes_used > 0 && $urandom_range(0, 9) < 7) begin
      slot       = $urandom_range(0, routes_used - 1);
      a.adv_dest = route_dest_m[slot];
      case ($urandom_range(0, 3))
        0, 1:    a.sender = route_hop_m[slot];
        2:       a.sender = $urandom_range(0, 7);
        default: a.sender = $urandom;
      endcase
    end else begin
      a.adv_dest = $urandom;
      a.sender   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
    end
    return a;
  endfunction

  // one command transfer; bursts keep start high, gaps drop it
  task automatic send_adv(adv_item_t a, bit typed, route_result_t want);
    int            gap;
    route_result_t model;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b1;
    item  <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    model = relax_route(a);
    pending_routes.insert(pending_routes.size(), typed ? want : model);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_routes();
    start     <= 1'b0;
    burst_left = 0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_infinity(logic [CostW-1:0] v);
    drain_routes();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    infinity_m = v;
  endtask

  task automatic note_mismatch(string what, route_result_t want, route_result_t got);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("%0t %s: want act %0d idx %0d cost %0d hop %h, got act %0d idx %0d cost %0d hop %h",
               $realtime, what, want.action, want.entry_index, want.result_cost,
               want.result_next_hop, got.action, got.entry_index, got.result_cost,
               got.result_next_hop);
  endtask

  // result transfer check against the oldest expectation
  always @(posedge clk) begin : check_routes
    route_result_t want;
    if (!rst && done) begin
      if (pending_routes.size() == 0) begin
        note_mismatch("unexpected result", '0, result);
      end else begin
        want = pending_routes.pop_front();
        if (result.action !== want.action || result.entry_index !== want.entry_index ||
            result.result_cost !== want.result_cost ||
            result.result_next_hop !== want.result_next_hop)
          note_mismatch("result mismatch", want, result);
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet_count <= 0;
    end else if (quiet_count >= WatchLimit) begin
      $display("[distance_vector_table_update] ERROR");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin : stimulus
    logic [CostW-1:0] inf_plan [PhaseCount];
    logic [CostW-1:0] inf_val;

    // directed plan, default infinity 999 after reset
    // first insertion lands in slot zero at zero cost
    add_row(adv_row(mk_adv('0, '0, '0, '0, '0), 1'b1,
                    mk_res(ACT_INSERTED, 0, '0, '0)));
    // all ones everywhere: sum saturates at infinity
    add_row(adv_row(mk_adv('1, '1, '1, '1, '1), 1'b1,
                    mk_res(ACT_INSERTED, 1, 16'd999, '1)));
    // current next hop, route got worse: forced rewrite
    add_row(adv_row(mk_adv('0, 16'd5, '0, 32'h11, 16'd5), 1'b0, '0));
    // other neighbor, dearer: left alone
    add_row(adv_row(mk_adv('0, 16'd15, 32'd7, 32'h22, 16'd5), 1'b1,
                    mk_res(ACT_UNCHANGED, 0, 16'd10, '0)));
    // other neighbor, strictly cheaper
    add_row(adv_row(mk_adv('0, 16'd3, 32'd7, 32'h22, 16'd2), 1'b0, '0));
    // forced rewrite that changes nothing
    add_row(adv_row(mk_adv('0, 16'd3, 32'd7, 32'h22, 16'd2), 1'b0, '0));
    add_row(adv_row(mk_adv('0, 16'd90, 32'd7, 32'h22, 16'd10), 1'b0, '0));
    add_row(adv_row(mk_adv('1, 16'd500, 32'd1, 32'd3, 16'd498), 1'b0, '0));
    add_row(adv_row(mk_adv(32'h1234_5678, 16'h8000, 32'd2, 32'hA5A5_A5A5, 16'h8000),
                    1'b0, '0));
    // widest infinity: the 17-bit sum still saturates
    add_row(cfg_row('1));
    add_row(adv_row(mk_adv(32'h1234_5678, '1, 32'd2, 32'h5A5A_5A5A, '1), 1'b0, '0));
    add_row(adv_row(mk_adv(32'h1234_5678, 16'd65534, 32'd3, '0, '0), 1'b0, '0));
    // zero infinity: every computed cost is zero
    add_row(cfg_row('0));
    add_row(adv_row(mk_adv('1, 16'd10, 32'd9, '0, 16'd10), 1'b0, '0));
    add_row(adv_row(mk_adv(32'h0F0F_0F0F, 16'h1234, 32'hF0F0_F0F0, 32'hFFFF_0000,
                           16'h4321), 1'b1, mk_res(ACT_INSERTED, 3, '0, 32'hF0F0_F0F0)));
    // lowered infinity: stored costs above it are compared as they are
    add_row(cfg_row(16'd1));
    add_row(adv_row(mk_adv(32'h1234_5678, 16'd1, 32'd4, '0, 16'd1), 1'b0, '0));
    add_row(adv_row(mk_adv('0, 16'd5, 32'd8, '0, '0), 1'b0, '0));
    add_row(adv_row(mk_adv(32'h0F0F_0F0F, '0, 32'hF0F0_F0F0, '0, '0), 1'b1,
                    mk_res(ACT_UNCHANGED, 3, '0, 32'hF0F0_F0F0)));

    inf_plan = '{16'hFFFF, 16'd1, 16'd0, 16'd20, 16'd999, 16'd0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_infinity(plan[i].cfg_val);
      else
        send_adv(plan[i].adv, plan[i].typed, plan[i].want);
    end

    // random phases, each behind its own infinity setting
    for (int ph = 0; ph < PhaseCount; ph++) begin
      inf_val = (ph == PhaseCount - 1) ? CostW'($urandom_range(1, 65535)) : inf_plan[ph];
      write_infinity(inf_val);
      for (int n = 0; n < PhaseItems; n++)
        send_adv(random_adv(), 1'b0, '0);
    end

    drain_routes();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_routes.size() == 0)
      $display("[distance_vector_table_update] OK");
    else
      $display("[distance_vector_table_update] ERROR");
    $finish;
  end

endmodule
